@@ design/smdu_pkg.sv @@
// package for the signed multiply/divide unit
// holds width constants and operation codes; no dependencies
package smdu_pkg;
  localparam int DataWidthDefault = 64;
  localparam int OperandWidth = 64;
  localparam int TagWidth = 8;
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;
  localparam logic EXC_NONE = 1'b0;
  localparam logic EXC_DIV_ZERO = 1'b1;
endpackage

@@ design/signed_mul_div_unit_top.sv @@
// signed multiply/divide unit, top level
// depends on smdu_pkg
// Fully pipelined: one request is accepted every cycle while the output is not
// stalled, and each result passes through an entry stage, DATA_WIDTH
// restoring-divide stages with one bit of quotient per stage, and the output
// register. The multiply is built from three 32x32 partial products in the
// first divide stage and summed in the second, and it rides beside the divide
// chain so that both kinds of request share one latency and results leave in
// request order. A stall on the output holds the whole pipeline; the output
// register keeps the finished result, and the next request is taken whenever
// that register is free or being emptied.
module signed_mul_div_unit_top #(
  parameter int DATA_WIDTH = smdu_pkg::DataWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operand_a[63:0], operand_b[127:64], dest_tag[135:128]
  input  logic [135:0] s_tdata,
  // operation
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_tag[7:0], result_value[71:8], exception_code[72], negative_flag[73],
  // zero_flag[74], zero fill[79:75]
  output logic [79:0]  m_tdata
);
  import smdu_pkg::*;

  localparam int W = DATA_WIDTH;

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // entry stage
  logic [W-1:0] a_in, b_in;
  assign a_in = s_tdata[W-1:0];
  assign b_in = s_tdata[OperandWidth+W-1:OperandWidth];

  // per-stage pipeline registers; stage 0 is entry
  logic               vld  [W+1];
  logic               op   [W+1];
  logic [TagWidth-1:0] tag [W+1];
  logic               dz   [W+1];
  logic               neg  [W+1];
  logic [W-1:0]       rem  [W+1];
  logic [W-1:0]       quo  [W+1];
  logic [W-1:0]       dvs  [W+1];
  logic [W-1:0]       prod [W+1];
  logic [31:0]        pp0;
  logic [63:0]        pp1;
  logic [31:0]        a_hi_d;

  // stage 0: absolute values, multiply operands
  logic [63:0] a64, b64;
  assign a64 = 64'($signed(a_in));
  assign b64 = 64'($signed(b_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_tvalid;
    end
    if (adv) begin
      op[0]  <= s_tuser;
      tag[0] <= s_tdata[2*OperandWidth+TagWidth-1:2*OperandWidth];
      dz[0]  <= (b_in == '0);
      neg[0] <= a_in[W-1] ^ b_in[W-1];
      rem[0] <= '0;
      quo[0] <= a_in[W-1] ? W'(-a_in) : a_in;
      dvs[0] <= b_in[W-1] ? W'(-b_in) : b_in;
      pp0    <= a64[31:0];
      pp1    <= b64;
      a_hi_d <= a64[63:32];
      prod[0] <= '0;
    end
  end

  // stage 1: three 32x32 partial products
  logic [63:0] p_ll;
  logic [31:0] p_lh, p_hl;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_ll <= pp0 * pp1[31:0];
      p_lh <= pp0 * pp1[63:32];
      p_hl <= pp1[31:0] * a_hi_d;
    end
  end

  // divide chain: one quotient bit per stage
  genvar i;
  generate
    for (i = 0; i < W; i++) begin : g_div
      logic [W:0] trial;
      logic [W:0] shifted;
      assign shifted = {rem[i], quo[i][W-1]};
      assign trial = shifted - {1'b0, dvs[i]};
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i+1] <= 1'b0;
        end else if (adv) begin
          vld[i+1] <= vld[i];
        end
        if (adv) begin
          op[i+1]  <= op[i];
          tag[i+1] <= tag[i];
          dz[i+1]  <= dz[i];
          neg[i+1] <= neg[i];
          dvs[i+1] <= dvs[i];
          if (!trial[W]) begin
            rem[i+1] <= trial[W-1:0];
            quo[i+1] <= {quo[i][W-2:0], 1'b1};
          end else begin
            rem[i+1] <= shifted[W-1:0];
            quo[i+1] <= {quo[i][W-2:0], 1'b0};
          end
          if (i == 1) begin
            prod[i+1] <= W'(p_ll + {p_lh + p_hl, 32'd0});
          end else begin
            prod[i+1] <= prod[i];
          end
        end
      end
    end
  endgenerate

  // output stage
  logic [W-1:0] q_signed, res;
  assign q_signed = neg[W] ? W'(-quo[W]) : quo[W];
  always_comb begin
    if (op[W] == OP_MUL) res = prod[W];
    else if (dz[W]) res = '0;
    else res = q_signed;
  end

  logic [TagWidth-1:0] o_tag;
  logic [W-1:0] o_val;
  logic o_exc, o_neg, o_zero;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[W];
    end
    if (adv) begin
      o_tag  <= tag[W];
      o_val  <= res;
      o_exc  <= (op[W] == OP_DIV && dz[W]) ? EXC_DIV_ZERO : EXC_NONE;
      o_neg  <= res[W-1];
      o_zero <= (res == '0);
    end
  end

  assign m_tdata = {5'd0, o_zero, o_neg, o_exc, 64'(o_val), o_tag};

  logic unused;
  assign unused = ^{rem[W], dvs[W]};
endmodule
